### design/pcpfl_pkg.sv
// Shared types and codes for the per-CPU page free-list allocator.
`default_nettype none

package pcpfl_pkg;

  localparam int ADDR_W      = 34;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 34;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_STOP  = 1'b1;

  localparam logic [ADDR_W-1:0] REGION_STOP_RESET = 34'h0_8800_0000;

  typedef struct packed {
    logic              cmd;
    logic [2:0]        cpu_id;
    logic [ADDR_W-1:0] page_addr;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;
  } out_beat_t;

  // Classified request handed from front to back
  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_BAD
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LINK
  } back_state_t;

endpackage

`default_nettype wire

### design/pcpfl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pcpfl_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/pcpfl_front.sv
// Front part: region registers, request classification and the two-entry queue.
`default_nettype none

module pcpfl_front import pcpfl_pkg::*; #(
  parameter  int CPU_COUNT  = 8,
  parameter  int MAX_PAGES  = 32768,
  parameter  int PAGE_BYTES = 4096,
  localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
  localparam int IDX_W      = $clog2(MAX_PAGES)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_beat_t               in_data,
  output logic                        q_valid,
  input  wire logic                   q_pop,
  output item_kind_t                  q_kind,
  output logic      [CPU_W-1:0]       q_cpu,
  output logic      [IDX_W-1:0]       q_idx,
  output logic      [ADDR_W:0]        base
);

  localparam int PB_SH = $clog2(PAGE_BYTES);

  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] region_stop;
  logic [ADDR_W:0]   base_sum;
  logic [ADDR_W:0]   base_next;

  // Page base: region_start rounded up to a page boundary, worked out on the write
  assign base_sum  = {1'b0, cfg_data} + (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign base_next = {base_sum[ADDR_W:PB_SH], {PB_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_stop  <= REGION_STOP_RESET;
      base         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REGION_START: begin
          region_start <= cfg_data;
          base         <= base_next;
        end
        REG_REGION_STOP: begin
          region_stop <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // cpu_id modulo CPU_COUNT as a constant lookup
  logic [CPU_W-1:0] cpu_tab [8];
  for (genvar g = 0; g < 8; g++) begin : g_cpu_tab
    assign cpu_tab[g] = CPU_W'(g % CPU_COUNT);
  end

  logic [ADDR_W-1:0]   addr;
  logic                misaligned;
  logic                out_of_region;
  logic [ADDR_W:0]     diff;
  logic [ADDR_W-PB_SH:0] idx_full;
  logic                too_high;
  logic                bad;
  item_kind_t          kind;
  logic [CPU_W-1:0]    cpu;

  assign addr          = in_data.page_addr;
  assign misaligned    = |addr[PB_SH-1:0];
  assign out_of_region = (addr < region_start) || (addr >= region_stop) ||
                         ({1'b0, addr} < base);
  assign diff          = {1'b0, addr} - base;
  assign idx_full      = diff[ADDR_W:PB_SH];
  assign too_high      = 40'(idx_full) >= 40'(MAX_PAGES);
  assign bad           = misaligned || out_of_region || too_high;
  assign cpu           = cpu_tab[in_data.cpu_id];

  always_comb begin
    case (in_data.cmd)
      CMD_ALLOC: kind = KIND_ALLOC;
      CMD_FREE:  kind = bad ? KIND_BAD : KIND_FREE;
      default:   kind = KIND_BAD;
    endcase
  end

  // Two-entry queue between front and back
  item_kind_t       kind_q [2];
  logic [CPU_W-1:0] cpu_q  [2];
  logic [IDX_W-1:0] idx_q  [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_kind   = kind_q[rd_ptr];
  assign q_cpu    = cpu_q[rd_ptr];
  assign q_idx    = idx_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wr_ptr] <= kind;
      cpu_q[wr_ptr]  <= cpu;
      idx_q[wr_ptr]  <= idx_full[IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/pcpfl_back.sv
// Back part: list heads, link memory, pop/push sequencer and output register.
`default_nettype none

module pcpfl_back import pcpfl_pkg::*; #(
  parameter  int CPU_COUNT  = 8,
  parameter  int MAX_PAGES  = 32768,
  parameter  int PAGE_BYTES = 4096,
  localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1,
  localparam int IDX_W      = $clog2(MAX_PAGES)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire item_kind_t       q_kind,
  input  wire logic [CPU_W-1:0] q_cpu,
  input  wire logic [IDX_W-1:0] q_idx,
  input  wire logic [ADDR_W:0]  base,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_data
);

  localparam int PB_SH = $clog2(PAGE_BYTES);

  back_state_t state;
  back_state_t state_next;

  logic [CPU_COUNT-1:0] head_valid;
  item_kind_t           cur_kind;
  logic [CPU_W-1:0]     cur_cpu;
  logic [IDX_W-1:0]     cur_idx;
  logic [ADDR_W-1:0]    res_addr;

  logic             head_re;
  logic             head_we;
  logic [IDX_W-1:0] head_wdata;
  logic [IDX_W-1:0] head_rd;
  logic             link_re;
  logic             link_we;
  logic [IDX_W:0]   link_wdata;
  logic [IDX_W:0]   link_rd;
  logic             hv_we;
  logic             hv_wval;
  logic             load_cur;
  logic             res_load;
  logic             emit;
  out_beat_t        emit_beat;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  // Rotating search for the first non-empty list starting at the requester
  logic [2*CPU_COUNT-1:0] hv_dbl;
  logic [CPU_COUNT-1:0]   rot;
  logic [CPU_COUNT-1:0]   lowest;
  logic                   any_list;
  logic [CPU_W-1:0]       off;
  logic [CPU_W:0]         id_sum;
  logic [CPU_W-1:0]       victim;
  logic [CPU_W-1:0]       tgt;

  assign hv_dbl   = {head_valid, head_valid} >> q_cpu;
  assign rot      = hv_dbl[CPU_COUNT-1:0];
  assign lowest   = rot & (~rot + CPU_COUNT'(1));
  assign any_list = |rot;

  always_comb begin
    off = '0;
    for (int j = 0; j < CPU_COUNT; j++) begin
      if (lowest[j]) begin
        off = off | CPU_W'(j);
      end
    end
  end

  assign id_sum = {1'b0, q_cpu} + {1'b0, off};
  assign victim = (id_sum >= (CPU_W + 1)'(CPU_COUNT)) ?
                  CPU_W'(id_sum - (CPU_W + 1)'(CPU_COUNT)) : id_sum[CPU_W-1:0];
  assign tgt    = (q_kind == KIND_ALLOC) ? victim : q_cpu;

  assign link_wdata = {head_valid[cur_cpu], head_valid[cur_cpu] ? head_rd : IDX_W'(0)};

  logic [ADDR_W+1:0] page_sum;
  assign page_sum = (ADDR_W + 2)'(base) + ((ADDR_W + 2)'(head_rd) << PB_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    head_re    = 1'b0;
    head_we    = 1'b0;
    head_wdata = cur_idx;
    link_re    = 1'b0;
    link_we    = 1'b0;
    hv_we      = 1'b0;
    hv_wval    = 1'b1;
    load_cur   = 1'b0;
    res_load   = 1'b0;
    emit       = 1'b0;
    emit_beat  = '{result_addr: '0, status: STATUS_OK};
    case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_kind)
            KIND_ALLOC: begin
              if (any_list) begin
                head_re    = 1'b1;
                load_cur   = 1'b1;
                state_next = ST_HEAD;
              end else begin
                emit             = 1'b1;
                emit_beat.status = STATUS_EMPTY;
              end
            end
            KIND_FREE: begin
              head_re    = 1'b1;
              load_cur   = 1'b1;
              state_next = ST_HEAD;
            end
            default: begin
              emit             = 1'b1;
              emit_beat.status = STATUS_BAD_ADDR;
            end
          endcase
        end
      end
      ST_HEAD: begin
        if (cur_kind == KIND_ALLOC) begin
          link_re    = 1'b1;
          res_load   = 1'b1;
          state_next = ST_LINK;
        end else if (out_free) begin
          // push: old head becomes the new page's link
          link_we    = 1'b1;
          head_we    = 1'b1;
          hv_we      = 1'b1;
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LINK: begin
        if (out_free) begin
          head_we               = 1'b1;
          head_wdata            = link_rd[IDX_W-1:0];
          hv_we                 = 1'b1;
          hv_wval               = link_rd[IDX_W];
          emit                  = 1'b1;
          emit_beat.result_addr = res_addr;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
    end else if (hv_we) begin
      head_valid[cur_cpu] <= hv_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_kind <= q_kind;
      cur_cpu  <= tgt;
      cur_idx  <= q_idx;
    end
    if (res_load) begin
      res_addr <= page_sum[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_beat;
    end
  end

  pcpfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CPU_COUNT)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (cur_cpu),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (tgt),
    .rdata (head_rd)
  );

  pcpfl_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (cur_idx),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (head_rd),
    .rdata (link_rd)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a push may sit in the head state while the output is stalled
  a_head_from_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD) |-> ($past(state) == ST_IDLE || $past(state) == ST_HEAD))
    else $error("head lookup not started from idle");

  a_alloc_list_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD && cur_kind == KIND_ALLOC) |-> head_valid[cur_cpu])
    else $error("pop from an empty list");

  a_free_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD && cur_kind == KIND_FREE && out_free) |=>
      head_valid[$past(cur_cpu)])
    else $error("list still empty after push");

endmodule

`default_nettype wire

### design/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page free-list allocator.
//
// Requests enter on in_valid/in_stall/in_data: cmd 0 allocates a page for cpu_id,
// cmd 1 frees page_addr onto cpu_id's list. One result beat leaves on
// out_valid/out_stall/out_data for every request, in request order.
// An allocate pops the own list, else steals from the next non-empty list.
// Region bounds are written on cfg_write/cfg_index/cfg_data; the user must do so
// only while idle, as the block itself does not enforce it.
// An allocate reads the list-head RAM, then the link RAM; a free reads the list
// head, then writes link and head; a bad or empty request needs no RAM access.
// The back part takes the next request only when the current one is done; bad or
// empty requests go at one per cycle while the output is not stalled.
// A two-entry queue sits between classification and execution, so input beats
// keep being taken while the back part works or the output is stalled, until
// it is full. A stalled result holds in the output register; the back part waits.
// Reset: all lists empty, region_start 0, region_stop 0x88000000. The link
// memory is not cleared; a link is only read after its page was pushed.
`default_nettype none

module per_cpu_page_free_list_allocator import pcpfl_pkg::*; #(
  parameter int CPU_COUNT  = 8,
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_beat_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_beat_t                   out_data
);

  localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int IDX_W = $clog2(MAX_PAGES);

  // queue handoff
  logic             q_valid;
  logic             q_pop;
  item_kind_t       q_kind;
  logic [CPU_W-1:0] q_cpu;
  logic [IDX_W-1:0] q_idx;
  logic [ADDR_W:0]  base;

  pcpfl_front #(
    .CPU_COUNT  (CPU_COUNT),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_kind    (q_kind),
    .q_cpu     (q_cpu),
    .q_idx     (q_idx),
    .base      (base)
  );

  // execution: list heads, link memory, result register
  pcpfl_back #(
    .CPU_COUNT  (CPU_COUNT),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_kind    (q_kind),
    .q_cpu     (q_cpu),
    .q_idx     (q_idx),
    .base      (base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
